// ===== design/scr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequenced chunk receiver package
// Request and response types, command codes and status codes shared by the
// receiver's modules and its checker.
// ----------------------------------------------------------------------------
package scr_pkg;

   // Command codes carried by a request.
   localparam logic [1:0] CMD_BYTE   = 2'd0;
   localparam logic [1:0] CMD_ARM    = 2'd1;
   localparam logic [1:0] CMD_DISARM = 2'd2;

   // Status codes reported with each response.
   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_ACCEPTED = 3'd1;
   localparam logic [2:0] ST_MARKER   = 3'd2;
   localparam logic [2:0] ST_SMALL    = 3'd3;
   localparam logic [2:0] ST_ORDER    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;
   localparam logic [2:0] ST_UNARMED  = 3'd6;

   // Header byte that marks the obsolete end-of-transfer chunk.
   localparam logic [7:0] MARKER_BYTE = 8'hFF;

   // Number of header bytes at the start of every chunk.
   localparam int HeaderBytes = 2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       chunk_last;
   } request_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_out;
      logic        chunk_end;
      logic [2:0]  status;
      logic        armed_now;
      logic [31:0] total_received;
   } response_type;

endpackage
`default_nettype wire

// ===== design/scr_chunk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk control
// Holds the receiver state (armed flag, byte totals, expected sequence id,
// chunk byte count, header bytes) and judges one request per cycle in which a request is taken.
// ----------------------------------------------------------------------------
module scr_chunk_ctrl #(
   parameter int MAX_CHUNK_BYTES = 512
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_accept,
   input  wire scr_pkg::request_type req_data,
   input  wire [31:0]           transfer_size,
   output scr_pkg::response_type rsp_next
);

   // The count saturates one past the chunk limit.
   localparam int CountWidth = $clog2(MAX_CHUNK_BYTES + 2);
   localparam logic [CountWidth-1:0] MaxCount   = CountWidth'(MAX_CHUNK_BYTES);
   localparam logic [CountWidth-1:0] HeaderCnt  = CountWidth'(scr_pkg::HeaderBytes);
   localparam logic [CountWidth-1:0] MinLength  = CountWidth'(scr_pkg::HeaderBytes + 1);

   logic                  armed_ff, armed_in;
   logic [31:0]           bytes_ff, bytes_in;
   logic [15:0]           next_id_ff, next_id_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            hdr0_ff, hdr0_in;
   logic [7:0]            hdr1_ff, hdr1_in;

   logic [7:0]            hdr0_new;
   logic [7:0]            hdr1_new;
   logic [CountWidth-1:0] length;
   logic [CountWidth-1:0] payload_len;
   logic [32:0]           new_total;
   logic                  total_exceeded;
   logic                  is_payload;
   logic [2:0]            end_status;

   // Header capture and byte count for a chunk byte.
   assign hdr0_new    = (count_ff == '0) ? req_data.data_byte : hdr0_ff;
   assign hdr1_new    = (count_ff == CountWidth'(1)) ? req_data.data_byte : hdr1_ff;
   assign length      = (count_ff <= MaxCount) ? count_ff + CountWidth'(1) : count_ff;
   assign payload_len = length - HeaderCnt;
   assign is_payload  = (count_ff >= HeaderCnt) && (count_ff < MaxCount);

   // Running total check against the configured transfer size.
   assign new_total      = {1'b0, bytes_ff} + 33'(payload_len);
   assign total_exceeded = new_total > {1'b0, transfer_size};

   // Judgement of a finished chunk.
   always_comb begin
      if (length == HeaderCnt && hdr0_new == scr_pkg::MARKER_BYTE &&
          hdr1_new == scr_pkg::MARKER_BYTE) begin
         end_status = scr_pkg::ST_MARKER;
      end else if (length < MinLength) begin
         end_status = scr_pkg::ST_SMALL;
      end else if ({hdr1_new, hdr0_new} != next_id_ff) begin
         end_status = scr_pkg::ST_ORDER;
      end else if (length > MaxCount || total_exceeded) begin
         end_status = scr_pkg::ST_OVERFLOW;
      end else begin
         end_status = scr_pkg::ST_ACCEPTED;
      end
   end

   // Next state and response for the current request.
   always_comb begin
      armed_in   = armed_ff;
      bytes_in   = bytes_ff;
      next_id_in = next_id_ff;
      count_in   = count_ff;
      hdr0_in    = hdr0_ff;
      hdr1_in    = hdr1_ff;
      rsp_next   = '0;
      rsp_next.status = scr_pkg::ST_PENDING;

      unique case (req_data.command) inside
         scr_pkg::CMD_ARM, scr_pkg::CMD_DISARM: begin
            armed_in   = (req_data.command == scr_pkg::CMD_ARM);
            bytes_in   = '0;
            next_id_in = '0;
            count_in   = '0;
            hdr0_in    = '0;
            hdr1_in    = '0;
         end
         scr_pkg::CMD_BYTE: begin
            if (!armed_ff) begin
               rsp_next.status    = scr_pkg::ST_UNARMED;
               rsp_next.chunk_end = req_data.chunk_last;
            end else begin
               hdr0_in  = hdr0_new;
               hdr1_in  = hdr1_new;
               count_in = length;
               if (is_payload) begin
                  rsp_next.payload_valid = 1'b1;
                  rsp_next.payload_out   = req_data.data_byte;
               end
               if (req_data.chunk_last) begin
                  rsp_next.chunk_end = 1'b1;
                  rsp_next.status    = end_status;
                  count_in           = '0;
                  if (end_status == scr_pkg::ST_ACCEPTED) begin
                     bytes_in   = new_total[31:0];
                     next_id_in = next_id_ff + 16'd1;
                  end else if (end_status != scr_pkg::ST_MARKER) begin
                     // Any error disarms and clears the counters.
                     armed_in   = 1'b0;
                     bytes_in   = '0;
                     next_id_in = '0;
                     hdr0_in    = '0;
                     hdr1_in    = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rsp_next.armed_now      = armed_in;
      rsp_next.total_received = bytes_in;
   end

   // State registers, updated only when a request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         bytes_ff   <= '0;
         next_id_ff <= '0;
         count_ff   <= '0;
         hdr0_ff    <= '0;
         hdr1_ff    <= '0;
      end else if (req_accept) begin
         armed_ff   <= armed_in;
         bytes_ff   <= bytes_in;
         next_id_ff <= next_id_in;
         count_ff   <= count_in;
         hdr0_ff    <= hdr0_in;
         hdr1_ff    <= hdr1_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/scr_rsp_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response register
// Output stage that holds one response until the consumer takes it, and
// reloads in the same cycle the held response leaves.
// ----------------------------------------------------------------------------
module scr_rsp_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  wire scr_pkg::response_type load_data,
   input  wire                   rsp_stall,
   output logic                  rsp_valid,
   output scr_pkg::response_type rsp_data,
   output logic                  busy
);

   logic                  valid_ff;
   scr_pkg::response_type data_ff;

   // The stage can take a new response unless a held one is stalled.
   assign busy      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/sequenced_chunk_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequenced chunk receiver
// Takes chunk bytes one at a time, checks each chunk's sequence id, length
// and the running transfer total, and reports a status per request.
// ----------------------------------------------------------------------------
// Each request produces exactly one response, in the cycle after it is taken.
// A request is taken in every cycle in which the response register is empty
// or its response leaves, so the block sustains one byte per clock while
// responses are not stalled; the chunk control's state is registered when
// each request is taken. Payload bytes come out as they arrive and are to be
// kept only if the chunk ends with status accepted. Write transfer_size only
// while no request is in flight.
module sequenced_chunk_receiver #(
   parameter int MAX_CHUNK_BYTES = 512
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire scr_pkg::request_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output scr_pkg::response_type rsp_data,
   input  wire                   csr_wr_en,
   input  wire [31:0]            csr_wr_data
);

   logic                  transfer_size_ff;
   logic [31:0]           transfer_size_q_ff;
   logic                  req_accept;
   logic                  rsp_busy;
   scr_pkg::response_type rsp_next;

   assign req_stall  = rsp_busy;
   assign req_accept = req_valid && !rsp_busy;

   // Transfer size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_size_q_ff <= '0;
      end else if (csr_wr_en) begin
         transfer_size_q_ff <= csr_wr_data;
      end
   end

   // Marks that the size has been written since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_size_ff <= 1'b0;
      end else if (csr_wr_en) begin
         transfer_size_ff <= 1'b1;
      end
   end

   scr_chunk_ctrl #(
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_data      (req_data),
      .transfer_size (transfer_size_ff ? transfer_size_q_ff : 32'd0),
      .rsp_next      (rsp_next)
   );

   scr_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_data (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (rsp_busy)
   );

endmodule
`default_nettype wire

// ===== design/scr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequenced chunk receiver checker
// Port-level checks on the responses of the receiver.
// ----------------------------------------------------------------------------
module scr_port_checks (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input wire scr_pkg::response_type rsp_data
);

   // A stalled response stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Every judged status belongs to a chunk end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != scr_pkg::ST_PENDING &&
      rsp_data.status != scr_pkg::ST_UNARMED |-> rsp_data.chunk_end)
      else $error("chunk status without chunk end");

   // Errors disarm the block and clear the total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == scr_pkg::ST_SMALL ||
      rsp_data.status == scr_pkg::ST_ORDER || rsp_data.status == scr_pkg::ST_OVERFLOW)
      |-> !rsp_data.armed_now && rsp_data.total_received == 32'd0)
      else $error("error status left block armed or total nonzero");

   // No payload is passed while unarmed, and an empty payload slot is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.payload_valid ?
      (rsp_data.status != scr_pkg::ST_UNARMED) : (rsp_data.payload_out == 8'd0)))
      else $error("bad payload fields");

   // An accepted chunk keeps the block armed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == scr_pkg::ST_ACCEPTED |-> rsp_data.armed_now)
      else $error("accepted chunk without armed flag");

endmodule

bind sequenced_chunk_receiver scr_port_checks u_port_checks (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== test/scr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequenced chunk receiver checker
// Watches the request, response and register ports of the receiver, keeps
// its own model of the chunk state, and compares every response field by
// field with the one the model predicts for the matching request.
// ----------------------------------------------------------------------------
module scr_checker #(
   parameter int MAX_CHUNK_BYTES = 512
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  wire scr_pkg::request_type  req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  wire scr_pkg::response_type rsp_data,
   input  wire                   csr_wr_en,
   input  wire [31:0]            csr_wr_data,
   output int                    fail_count,
   output int                    pending_count
);

   // The model's chunk byte count saturates one past the size cap.
   localparam int LenWidth = $clog2(MAX_CHUNK_BYTES + 2);

   // Model state of the receiver.
   logic                armed_flag;
   logic [31:0]         accepted_total;
   logic [15:0]         expected_id;
   logic [LenWidth-1:0] chunk_len;
   logic [7:0]          header_lo;
   logic [7:0]          header_hi;
   logic [31:0]         size_limit;

   // Responses predicted for requests taken but not yet answered.
   scr_pkg::response_type predicted_q[$];

   // Clear the running totals and the chunk in progress.
   function automatic void clear_chunk_state();
      accepted_total = '0;
      expected_id    = '0;
      chunk_len      = '0;
      header_lo      = '0;
      header_hi      = '0;
   endfunction

   // Apply one request to the model and return the response it causes.
   function automatic scr_pkg::response_type judge_request(scr_pkg::request_type r);
      scr_pkg::response_type o;
      logic [15:0]           header_id;
      logic [32:0]           new_total;
      o = '0;
      o.status = scr_pkg::ST_PENDING;
      case (r.command)
         scr_pkg::CMD_ARM: begin
            armed_flag = 1'b1;
            clear_chunk_state();
         end
         scr_pkg::CMD_DISARM: begin
            armed_flag = 1'b0;
            clear_chunk_state();
         end
         scr_pkg::CMD_BYTE: begin
            if (!armed_flag) begin
               o.status    = scr_pkg::ST_UNARMED;
               o.chunk_end = r.chunk_last;
            end else begin
               // Header bytes are kept; payload is passed on up to the size cap.
               if (chunk_len == '0) begin
                  header_lo = r.data_byte;
               end else if (chunk_len == LenWidth'(1)) begin
                  header_hi = r.data_byte;
               end else if (chunk_len < LenWidth'(MAX_CHUNK_BYTES)) begin
                  o.payload_valid = 1'b1;
                  o.payload_out   = r.data_byte;
               end
               if (chunk_len <= LenWidth'(MAX_CHUNK_BYTES)) begin
                  chunk_len = chunk_len + LenWidth'(1);
               end

               // Judge the chunk on its last byte.
               if (r.chunk_last) begin
                  header_id = {header_hi, header_lo};
                  new_total = {1'b0, accepted_total} + 33'(chunk_len) -
                              33'(scr_pkg::HeaderBytes);
                  o.chunk_end = 1'b1;
                  if (chunk_len == LenWidth'(scr_pkg::HeaderBytes) &&
                      header_lo == scr_pkg::MARKER_BYTE &&
                      header_hi == scr_pkg::MARKER_BYTE) begin
                     o.status = scr_pkg::ST_MARKER;
                  end else if (chunk_len < LenWidth'(scr_pkg::HeaderBytes + 1)) begin
                     o.status = scr_pkg::ST_SMALL;
                  end else if (header_id != expected_id) begin
                     o.status = scr_pkg::ST_ORDER;
                  end else if (chunk_len > LenWidth'(MAX_CHUNK_BYTES) ||
                               new_total > {1'b0, size_limit}) begin
                     o.status = scr_pkg::ST_OVERFLOW;
                  end else begin
                     o.status       = scr_pkg::ST_ACCEPTED;
                     accepted_total = new_total[31:0];
                     expected_id    = expected_id + 16'd1;
                  end
                  if (o.status >= scr_pkg::ST_SMALL) begin
                     armed_flag = 1'b0;
                     clear_chunk_state();
                  end
                  chunk_len = '0;
               end
            end
         end
         default: begin
         end
      endcase
      o.armed_now      = armed_flag;
      o.total_received = accepted_total;
      return o;
   endfunction

   // Compare one response field and count a mismatch.
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // Responses are checked before requests are predicted, since a response
   // always belongs to a request taken at an earlier edge.
   always @(posedge clock) begin : track
      scr_pkg::response_type want;
      if (reset) begin
         armed_flag = 1'b0;
         size_limit = '0;
         clear_chunk_state();
         predicted_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_q.size() == 0) begin
               fail_count++;
               $error("response arrived with no request outstanding");
            end else begin
               want = predicted_q.pop_front();
               check_field("payload_valid", want.payload_valid, rsp_data.payload_valid);
               check_field("payload_out", want.payload_out, rsp_data.payload_out);
               check_field("chunk_end", want.chunk_end, rsp_data.chunk_end);
               check_field("status", want.status, rsp_data.status);
               check_field("armed_now", want.armed_now, rsp_data.armed_now);
               check_field("total_received", want.total_received,
                           rsp_data.total_received);
            end
         end
         if (req_valid && !req_stall) begin
            predicted_q.push_back(judge_request(req_data));
         end
         if (csr_wr_en) begin
            size_limit = csr_wr_data;
         end
      end
      pending_count = predicted_q.size();
   end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequenced chunk receiver testbench
// Drives directed and random chunk traffic into the receiver under several
// transfer sizes, with random gaps and stalls on both sides, and takes the
// verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MaxChunkBytes = 512;
   // Command code the block leaves without effect.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RandomItems = 1350;
   localparam int QuietChunks = 30;
   localparam int HoldOffCycles = 400;
   localparam int DrainLimit = 20000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   scr_pkg::request_type  req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   scr_pkg::response_type rsp_data;
   logic                  csr_wr_en;
   logic [31:0]           csr_wr_data;
   int                    fail_count;
   int                    pending_count;

   // Mode flags shared between the sender and the receiver processes, and the sender's item count.
   logic quiet_mode  = 1'b0;
   logic hold_off_go = 1'b0;
   int   items_sent  = 0;

   sequenced_chunk_receiver #(
      .MAX_CHUNK_BYTES(MaxChunkBytes)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   scr_checker #(
      .MAX_CHUNK_BYTES(MaxChunkBytes)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #10000000;
      $display("FAIL");
      $finish;
   end

   // Receiver side: random stalls, one long hold-off, none in quiet mode.
   initial begin : receiver
      int  hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldOffCycles - 1;
            rsp_stall <= 1'b1;
         end else if (quiet_mode) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 9);
         end
      end
   end

   // Offer one request, with a random gap first, and wait until it is taken.
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] value,
                               input logic last);
      scr_pkg::request_type r;
      r.command    = cmd;
      r.data_byte  = value;
      r.chunk_last = last;
      while (!quiet_mode && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Send one chunk: little-endian id, then random payload, len bytes in all.
   task automatic send_chunk(input logic [15:0] id, input int len);
      for (int i = 0; i < len; i++) begin
         logic [7:0] value;
         if (i == 0) begin
            value = id[7:0];
         end else if (i == 1) begin
            value = id[15:8];
         end else begin
            value = 8'($urandom_range(0, 255));
         end
         send_request(scr_pkg::CMD_BYTE, value, i == len - 1);
      end
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write the transfer size while the block is idle.
   task automatic write_transfer_size(input logic [31:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      int          phase;
      int          start_items;
      int          chunk_count;
      int          pick;
      int          len;
      int          guard;
      logic [1:0]  cmd;
      logic [15:0] next_id;
      logic [15:0] bad_id;
      logic [31:0] size_pick;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset transfer size of zero.
      send_request(scr_pkg::CMD_BYTE, 8'h00, 1'b0);
      send_request(scr_pkg::CMD_BYTE, 8'hFF, 1'b1);
      send_request(CMD_UNUSED, 8'hA5, 1'b1);
      send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
      send_chunk(16'hFFFF, 2);
      send_chunk(16'h0000, 3);
      send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
      send_chunk(16'h0000, 1);
      send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
      send_chunk(16'h0000, 2);

      // Directed part with the largest transfer size.
      write_transfer_size(32'hFFFF_FFFF);
      send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
      send_chunk(16'h0000, 4);
      send_chunk(16'h0007, 3);
      send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
      send_chunk(16'h0000, 3);
      send_request(scr_pkg::CMD_DISARM, 8'h00, 1'b0);

      // Long stretch of in-order chunks with no idling on either side.
      wait_idle();
      quiet_mode <= 1'b1;
      send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
      for (int i = 0; i < QuietChunks; i++) begin
         send_chunk(16'(i), $urandom_range(3, 12));
      end
      wait_idle();
      quiet_mode <= 1'b0;

      // Random phases, each with its own transfer size.
      start_items = items_sent;
      phase       = 0;
      while (items_sent - start_items < RandomItems) begin
         case (phase % 5)
            0, 2: size_pick = $urandom_range(0, 80);
            1: size_pick = 32'hFFFF_FFFF;
            3: size_pick = 32'h0000_0000;
            default: size_pick = $urandom;
         endcase
         write_transfer_size(size_pick);
         send_request(scr_pkg::CMD_ARM, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         next_id = '0;
         if (phase == 0) begin
            hold_off_go <= 1'b1;
         end

         // Chunks at and just past the size cap.
         if (phase == 1) begin
            send_chunk(next_id, MaxChunkBytes);
            next_id++;
            send_chunk(next_id, MaxChunkBytes + 1);
            send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
            next_id = '0;
         end

         chunk_count = $urandom_range(10, 40);
         for (int c = 0; c < chunk_count; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               // Noise: any command with random content.
               cmd = 2'($urandom_range(0, 3));
               send_request(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               if (cmd == scr_pkg::CMD_ARM || cmd == scr_pkg::CMD_DISARM) begin
                  next_id = '0;
               end
            end else if (pick < 10) begin
               send_request(scr_pkg::CMD_ARM, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
               next_id = '0;
            end else if (pick < 16) begin
               // Short chunk, either the end marker or too small.
               len = $urandom_range(1, 2);
               if ($urandom_range(0, 1) == 0) begin
                  send_chunk(16'hFFFF, len);
               end else begin
                  send_chunk(16'($urandom_range(0, 65535)), len);
               end
               if ($urandom_range(0, 3) != 0) begin
                  send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
                  next_id = '0;
               end
            end else if (pick < 23) begin
               // Out-of-order chunk.
               bad_id = next_id ^ 16'($urandom_range(1, 65535));
               send_chunk(bad_id, $urandom_range(3, 12));
               if ($urandom_range(0, 3) != 0) begin
                  send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
                  next_id = '0;
               end
            end else if (pick < 24) begin
               // Rare long chunk around the size cap.
               len = $urandom_range(MaxChunkBytes - 2, MaxChunkBytes + 3);
               send_chunk(next_id, len);
               next_id++;
               if (len > MaxChunkBytes) begin
                  send_request(scr_pkg::CMD_ARM, 8'h00, 1'b0);
                  next_id = '0;
               end
            end else begin
               send_chunk(next_id, $urandom_range(3, 12));
               next_id++;
            end
         end
         phase++;
      end

      // Drain and decide.
      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(negedge clock);
         guard++;
      end while (pending_count != 0 && guard < DrainLimit);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         if (pending_count != 0) begin
            $error("%0d responses never arrived", pending_count);
         end
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
